@@ hw/rtl/fixed_priority_bus_arbiter_core_defines.svh @@
// Assertion macros used by the checker file.
`ifndef FIXED_PRIORITY_BUS_ARBITER_CORE_DEFINES_SVH
`define FIXED_PRIORITY_BUS_ARBITER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define FPBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpba: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define FPBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpba: next-cycle check failed");

`endif

@@ hw/rtl/fpba_pkg.sv @@
`timescale 1ns / 1ps

package fpba_pkg;

    // Number of masters on the bus; per-master fields carry at most FieldWidth.
    localparam int NumMasters    = 4;
    localparam int FieldWidth    = 4;
    localparam int SelWidth      = 2;
    localparam int ActiveMasters = (NumMasters < FieldWidth) ? NumMasters : FieldWidth;

    localparam int InFieldBits   = 5 * FieldWidth + 5;
    localparam int OutFieldBits  = 5 * FieldWidth + 2 * SelWidth + 4;
    localparam int InTdataWidth  = ((InFieldBits + 7) / 8) * 8;
    localparam int OutTdataWidth = ((OutFieldBits + 7) / 8) * 8;

    // Input beat, lowest field last (packed structs fill from the MSB down).
    typedef struct packed {
        logic [InTdataWidth-InFieldBits-1:0] pad;
        logic                  slave_r_valid;
        logic                  slave_ar_ready;
        logic                  slave_b_valid;
        logic                  slave_w_ready;
        logic                  slave_aw_ready;
        logic [FieldWidth-1:0] master_r_ready;
        logic [FieldWidth-1:0] master_b_ready;
        logic [FieldWidth-1:0] master_ar_valid;
        logic [FieldWidth-1:0] master_w_valid;
        logic [FieldWidth-1:0] master_aw_valid;
    } in_item_t;

    // Result beat, lowest field last.
    typedef struct packed {
        logic [OutTdataWidth-OutFieldBits-1:0] pad;
        logic                  slave_r_ready;
        logic [FieldWidth-1:0] master_r_valid;
        logic [FieldWidth-1:0] master_ar_ready;
        logic [SelWidth-1:0]   read_select;
        logic                  slave_ar_valid;
        logic                  slave_b_ready;
        logic [FieldWidth-1:0] master_b_valid;
        logic [FieldWidth-1:0] master_w_ready;
        logic [FieldWidth-1:0] master_aw_ready;
        logic [SelWidth-1:0]   write_select;
        logic                  slave_aw_w_valid;
    } out_item_t;

    typedef struct packed {
        logic                found;
        logic [SelWidth-1:0] idx;
    } pick_t;

    // Lowest set bit among the active masters.
    function automatic pick_t first_set(input logic [FieldWidth-1:0] bits);
        pick_t p;
        p.found = 1'b0;
        p.idx   = '0;
        for (int i = ActiveMasters - 1; i >= 0; i--) begin
            if (bits[i]) begin
                p.found = 1'b1;
                p.idx   = SelWidth'(i);
            end
        end
        return p;
    endfunction

    // Place one bit at a master's position.
    function automatic logic [FieldWidth-1:0] to_master(input logic bit_in,
                                                         input logic [SelWidth-1:0] idx);
        return {{(FieldWidth-1){1'b0}}, bit_in} << idx;
    endfunction

endpackage

@@ hw/rtl/fixed_priority_bus_arbiter_core.sv @@
`timescale 1ns / 1ps

// Fixed-priority arbiter for the write and read handshakes of several bus
// masters toward one slave; the lowest master index wins on each channel. One
// beat on s_ carries a cycle's worth of master and slave handshake bits, and
// one beat on m_ returns the valid/ready bits to drive and the select indices
// for the external address, data and response muxes. A beat is accepted every
// cycle while m_ is not stalled, and passes through the input register and then
// the result register, with the priority pick and the owner update done in
// the single combinational step between them. The owner state moves only when
// a beat passes into the result register, so stalls on m_ hold it.
module fixed_priority_bus_arbiter_core
    import fpba_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // [3:0] master_aw_valid, [7:4] master_w_valid, [11:8] master_ar_valid,
    // [15:12] master_b_ready, [19:16] master_r_ready, [20] slave_aw_ready,
    // [21] slave_w_ready, [22] slave_b_valid, [23] slave_ar_ready,
    // [24] slave_r_valid, [31:25] zero
    input  logic [InTdataWidth-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [0] slave_aw_w_valid, [2:1] write_select, [6:3] master_aw_ready,
    // [10:7] master_w_ready, [14:11] master_b_valid, [15] slave_b_ready,
    // [16] slave_ar_valid, [18:17] read_select, [22:19] master_ar_ready,
    // [26:23] master_r_valid, [27] slave_r_ready, [31:28] zero
    output logic [OutTdataWidth-1:0] m_tdata
);

    logic                in_valid_reg;
    in_item_t            in_data_reg;
    logic                out_valid_reg;
    out_item_t           out_data_reg;
    logic                write_busy_reg, write_busy_next;
    logic [SelWidth-1:0] write_owner_reg, write_owner_next;
    logic                read_busy_reg, read_busy_next;
    logic [SelWidth-1:0] read_owner_reg, read_owner_next;
    out_item_t           res_next;
    logic                out_ready;
    logic                advance;
    pick_t               wr_pick;
    pick_t               rd_pick;

    // Flow control: each stage moves when the one after it can take a beat.
    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign wr_pick = first_set(in_data_reg.master_aw_valid & in_data_reg.master_w_valid);
    assign rd_pick = first_set(in_data_reg.master_ar_valid);

    // Write channel: offer the candidate while idle, route the response while busy.
    always_comb begin
        res_next         = '0;
        write_busy_next  = write_busy_reg;
        write_owner_next = write_owner_reg;
        read_busy_next   = read_busy_reg;
        read_owner_next  = read_owner_reg;

        if (!write_busy_reg) begin
            if (wr_pick.found) begin
                res_next.slave_aw_w_valid = 1'b1;
                res_next.write_select     = wr_pick.idx;
                res_next.master_aw_ready  = to_master(in_data_reg.slave_aw_ready, wr_pick.idx);
                res_next.master_w_ready   = to_master(in_data_reg.slave_w_ready, wr_pick.idx);
                if (in_data_reg.slave_aw_ready && in_data_reg.slave_w_ready) begin
                    write_busy_next  = 1'b1;
                    write_owner_next = wr_pick.idx;
                end
            end
        end else begin
            res_next.write_select   = write_owner_reg;
            res_next.master_b_valid = to_master(in_data_reg.slave_b_valid, write_owner_reg);
            res_next.slave_b_ready  = in_data_reg.master_b_ready[write_owner_reg];
            if (in_data_reg.slave_b_valid && in_data_reg.master_b_ready[write_owner_reg]) begin
                write_busy_next = 1'b0;
            end
        end

        // Read channel: same scheme on address-read and read data.
        if (!read_busy_reg) begin
            if (rd_pick.found) begin
                res_next.slave_ar_valid  = 1'b1;
                res_next.read_select     = rd_pick.idx;
                res_next.master_ar_ready = to_master(in_data_reg.slave_ar_ready, rd_pick.idx);
                if (in_data_reg.slave_ar_ready) begin
                    read_busy_next  = 1'b1;
                    read_owner_next = rd_pick.idx;
                end
            end
        end else begin
            res_next.read_select    = read_owner_reg;
            res_next.master_r_valid = to_master(in_data_reg.slave_r_valid, read_owner_reg);
            res_next.slave_r_ready  = in_data_reg.master_r_ready[read_owner_reg];
            if (in_data_reg.slave_r_valid && in_data_reg.master_r_ready[read_owner_reg]) begin
                read_busy_next = 1'b0;
            end
        end
    end

    // Control registers: stage valids and channel ownership.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            write_busy_reg  <= 1'b0;
            write_owner_reg <= '0;
            read_busy_reg   <= 1'b0;
            read_owner_reg  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg   <= 1'b1;
                write_busy_reg  <= write_busy_next;
                write_owner_reg <= write_owner_next;
                read_busy_reg   <= read_busy_next;
                read_owner_reg  <= read_owner_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: capture on each accepted beat.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= in_item_t'(s_tdata);
        end
        if (advance) begin
            out_data_reg <= res_next;
        end
    end

endmodule

@@ hw/rtl/fpba_checker.sv @@
`timescale 1ns / 1ps
`include "fixed_priority_bus_arbiter_core_defines.svh"

module fpba_checker
    import fpba_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [OutTdataWidth-1:0] m_tdata
);

    out_item_t res;
    logic      out_stall;
    logic      wr_no_offer;
    logic      wr_rdy_none;
    logic      b_beat;
    logic      wr_offer_none;
    logic      ar_beat;
    logic      ar_sel_ok;

    assign res           = out_item_t'(m_tdata);
    assign out_stall     = m_tvalid && !m_tready;
    assign wr_no_offer   = m_tvalid && !res.slave_aw_w_valid;
    assign wr_rdy_none   = (res.master_aw_ready == '0) && (res.master_w_ready == '0);
    assign b_beat        = m_tvalid && (res.master_b_valid != '0);
    assign wr_offer_none = !res.slave_aw_w_valid && (res.master_aw_ready == '0);
    assign ar_beat       = m_tvalid && (res.master_ar_ready != '0);
    assign ar_sel_ok     = (res.master_ar_ready == to_master(1'b1, res.read_select))
                           && res.slave_ar_valid;

    // Hold a stalled result beat.
    `FPBA_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid && $stable(m_tdata))

    // No write readies without a write offer.
    `FPBA_ASSERT_IMPLY(a_wr_ready_needs_offer, aclk, aresetn, wr_no_offer, wr_rdy_none)

    // A write response and a write offer never share a beat.
    `FPBA_ASSERT_IMPLY(a_wr_busy_excl, aclk, aresetn, b_beat, wr_offer_none)

    // Read address ready goes to the selected master only.
    `FPBA_ASSERT_IMPLY(a_rd_ready_sel, aclk, aresetn, ar_beat, ar_sel_ok)

endmodule

bind fixed_priority_bus_arbiter_core fpba_checker u_fpba_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import fpba_pkg::*;

    // Receiver stall patterns
    typedef enum int {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_e;

    localparam int NumRandom   = 1300;
    localparam int PhaseLen    = 260;
    localparam int LongHold    = 80;
    localparam int DrainCycles = 8;
    localparam int MaxPrinted  = 20;

    // Tracks channel ownership and holds the expected select/handshake beats.
    class arb_scoreboard;
        logic                wr_busy;
        logic [SelWidth-1:0] wr_owner;
        logic                rd_busy;
        logic [SelWidth-1:0] rd_owner;
        out_item_t           expected_grants[$];
        int                  errors;
        int                  beat_no;

        function new();
            wr_busy  = 1'b0;
            wr_owner = '0;
            rd_busy  = 1'b0;
            rd_owner = '0;
            errors   = 0;
            beat_no  = 0;
        endfunction

        // Lowest active master with its bit set; ActiveMasters if none.
        function int lowest_requester(logic [FieldWidth-1:0] bits);
            for (int i = 0; i < ActiveMasters; i++) begin
                if (bits[i]) return i;
            end
            return ActiveMasters;
        endfunction

        function int pending();
            return expected_grants.size();
        endfunction

        // Work out the outputs for one accepted input beat and advance the owners.
        function void predict_grants(in_item_t it);
            out_item_t o;
            int        c;
            o = '0;

            // Write channel: offer while idle, route the response while owned
            if (!wr_busy) begin
                c = lowest_requester(it.master_aw_valid & it.master_w_valid);
                if (c < ActiveMasters) begin
                    o.slave_aw_w_valid = 1'b1;
                    o.write_select     = c[SelWidth-1:0];
                    o.master_aw_ready  = FieldWidth'(it.slave_aw_ready) << c;
                    o.master_w_ready   = FieldWidth'(it.slave_w_ready) << c;
                    if (it.slave_aw_ready && it.slave_w_ready) begin
                        wr_owner = c[SelWidth-1:0];
                        wr_busy  = 1'b1;
                    end
                end
            end else begin
                o.write_select   = wr_owner;
                o.master_b_valid = FieldWidth'(it.slave_b_valid) << wr_owner;
                o.slave_b_ready  = it.master_b_ready[wr_owner];
                if (it.slave_b_valid && it.master_b_ready[wr_owner]) wr_busy = 1'b0;
            end

            // Read channel: same scheme with ar / r
            if (!rd_busy) begin
                c = lowest_requester(it.master_ar_valid);
                if (c < ActiveMasters) begin
                    o.slave_ar_valid  = 1'b1;
                    o.read_select     = c[SelWidth-1:0];
                    o.master_ar_ready = FieldWidth'(it.slave_ar_ready) << c;
                    if (it.slave_ar_ready) begin
                        rd_owner = c[SelWidth-1:0];
                        rd_busy  = 1'b1;
                    end
                end
            end else begin
                o.read_select    = rd_owner;
                o.master_r_valid = FieldWidth'(it.slave_r_valid) << rd_owner;
                o.slave_r_ready  = it.master_r_ready[rd_owner];
                if (it.slave_r_valid && it.master_r_ready[rd_owner]) rd_busy = 1'b0;
            end

            expected_grants.push_back(o);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            if (errors < MaxPrinted)
                $display("ERROR: result beat %0d: %s got %0h, want %0h",
                         beat_no, what, got, want);
            errors++;
        endtask

        task compare(string what, logic [31:0] got, logic [31:0] want);
            if (got !== want) report(what, got, want);
        endtask

        // Compare one result beat against the oldest expectation.
        task check_grants(out_item_t got);
            out_item_t want;
            if (expected_grants.size() == 0) begin
                report("unexpected beat", got, '0);
            end else begin
                want = expected_grants.pop_front();
                compare("slave_aw_w_valid", 32'(got.slave_aw_w_valid),
                        32'(want.slave_aw_w_valid));
                compare("write_select", 32'(got.write_select), 32'(want.write_select));
                compare("master_aw_ready", 32'(got.master_aw_ready),
                        32'(want.master_aw_ready));
                compare("master_w_ready", 32'(got.master_w_ready), 32'(want.master_w_ready));
                compare("master_b_valid", 32'(got.master_b_valid), 32'(want.master_b_valid));
                compare("slave_b_ready", 32'(got.slave_b_ready), 32'(want.slave_b_ready));
                compare("slave_ar_valid", 32'(got.slave_ar_valid), 32'(want.slave_ar_valid));
                compare("read_select", 32'(got.read_select), 32'(want.read_select));
                compare("master_ar_ready", 32'(got.master_ar_ready),
                        32'(want.master_ar_ready));
                compare("master_r_valid", 32'(got.master_r_valid), 32'(want.master_r_valid));
                compare("slave_r_ready", 32'(got.slave_r_ready), 32'(want.slave_r_ready));
                compare("pad", 32'(got.pad), 32'(want.pad));
            end
            beat_no++;
        endtask
    endclass

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [InTdataWidth-1:0]  s_tdata  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OutTdataWidth-1:0] m_tdata;

    rx_mode_e      rx_mode     = RX_ALWAYS;
    logic          hold_active = 1'b0;
    int unsigned   rx_cycle    = 0;
    event          long_hold_go;
    arb_scoreboard sb          = new();

    fixed_priority_bus_arbiter_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Sample both channels on the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.predict_grants(in_item_t'(s_tdata));
            if (m_tvalid && m_tready) sb.check_grants(out_item_t'(m_tdata));
        end
    end

    // Receiver: stall on the current pattern, or hold off entirely
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (hold_active) begin
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:   m_tready <= 1'b1;
                RX_MOSTLY:   m_tready <= ($urandom_range(0, 9) < 7);
                RX_SPARSE:   m_tready <= ($urandom_range(0, 9) < 3);
                RX_PERIODIC: m_tready <= ((rx_cycle % 7) < 4);
                default:     m_tready <= 1'b1;
            endcase
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering beats
    always begin
        @(long_hold_go);
        hold_active = 1'b1;
        repeat (LongHold) @(posedge aclk);
        hold_active = 1'b0;
    end

    function automatic in_item_t make_beat(logic [3:0] aw, logic [3:0] w, logic [3:0] ar,
                                           logic [3:0] br, logic [3:0] rr, logic s_awr,
                                           logic s_wr, logic s_bv, logic s_arr,
                                           logic s_rv);
        in_item_t it;
        it                 = '0;
        it.master_aw_valid = aw;
        it.master_w_valid  = w;
        it.master_ar_valid = ar;
        it.master_b_ready  = br;
        it.master_r_ready  = rr;
        it.slave_aw_ready  = s_awr;
        it.slave_w_ready   = s_wr;
        it.slave_b_valid   = s_bv;
        it.slave_ar_ready  = s_arr;
        it.slave_r_valid   = s_rv;
        return it;
    endfunction

    // Mostly coherent requests with busy slave readies; some pure noise
    function automatic in_item_t random_beat();
        logic [3:0] aw;
        logic [3:0] w;
        aw = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 9) == 0) begin
            w = 4'($urandom_range(0, 15));
            return make_beat(aw, w, 4'($urandom), 4'($urandom), 4'($urandom),
                             1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                             1'($urandom));
        end
        w = ($urandom_range(0, 3) != 0) ? (aw | 4'($urandom)) : 4'($urandom);
        return make_beat(aw, w, 4'($urandom), 4'($urandom), 4'($urandom),
                         ($urandom_range(0, 9) < 6), ($urandom_range(0, 9) < 7),
                         ($urandom_range(0, 9) < 6), ($urandom_range(0, 9) < 6),
                         ($urandom_range(0, 9) < 6));
    endfunction

    // Offer one beat and hold it until accepted
    task automatic send_beat(input in_item_t it);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid for a number of cycles with junk on the data lines
    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= InTdataWidth'($urandom);
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        logic [3:0] hi_mask;
        logic [3:0] own_bit;
        int         burst_left;
        int         phase;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: idle, mismatched write valids, full request, release
        send_beat(make_beat(4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_beat(make_beat(4'b0001, 4'b0010, 4'h0, 4'hF, 4'hF,
                            1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        send_beat(make_beat(4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        send_beat(make_beat(4'h0, 4'h0, 4'h0, 4'hF, 4'hF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));

        // Directed per master: offer, grant, response held off, release
        for (int m = 0; m < ActiveMasters; m++) begin
            hi_mask = 4'hF << m;
            own_bit = 4'b0001 << m;
            send_beat(make_beat(hi_mask, hi_mask, hi_mask, 4'h0, 4'h0,
                                1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
            send_beat(make_beat(hi_mask, hi_mask, hi_mask, 4'h0, 4'h0,
                                1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
            send_beat(make_beat(4'h0, 4'h0, 4'h0, ~own_bit, ~own_bit,
                                1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
            send_beat(make_beat(4'h0, 4'h0, 4'h0, own_bit, own_bit,
                                1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        end

        // Random beats in phases of different stall behavior
        burst_left = 0;
        for (int n = 0; n < NumRandom; n++) begin
            phase = n / PhaseLen;
            case (phase)
                0:       rx_mode = RX_ALWAYS;
                1:       rx_mode = RX_MOSTLY;
                2:       rx_mode = RX_SPARSE;
                3:       rx_mode = RX_PERIODIC;
                default: rx_mode = RX_MOSTLY;
            endcase
            if (n == 400) -> long_hold_go;
            if (n == 800) begin
                idle_cycles(1);
                wait_drained();
            end
            if (phase != 0) begin
                if (burst_left == 0) begin
                    if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
                    burst_left = $urandom_range(1, 40);
                end
                burst_left--;
            end
            send_beat(random_beat());
        end

        // Drain and finish
        idle_cycles(1);
        rx_mode = RX_ALWAYS;
        wait_drained();
        repeat (DrainCycles) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("fixed_priority_bus_arbiter_core: match");
        end else begin
            $display("fixed_priority_bus_arbiter_core: mismatch");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("fixed_priority_bus_arbiter_core: mismatch");
        $finish;
    end

endmodule
